FILE: rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel pipeline.
`default_nettype none

package rgbhsv_pkg;

    // Field widths
    localparam int CH_W   = 8;             // one color channel
    localparam int HUE_W  = 9;             // hue in degrees
    localparam int PCT_W  = 7;             // percent fields
    localparam int QUO_W  = 9;             // quotient bits of each divider
    localparam int NUM_W  = CH_W + QUO_W;  // divider numerator width

    // Arithmetic constants
    localparam int HUE_STEP = 60;          // degrees per sector
    localparam int HUE_RED  = 360;         // sector offsets
    localparam int HUE_GRN  = 120;
    localparam int HUE_BLU  = 240;
    localparam int PCT_FULL = 100;
    localparam logic [QUO_W-1:0] HUE_WRAP = QUO_W'(360);

    // Input beat
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_in_t;

    // Output beat
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } hsv_out_t;

    // Channel that holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } hue_sect_t;

    // Operands of one divider
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [CH_W-1:0]  den;
    } div_in_t;

    // Sideband carried next to the dividers
    typedef struct packed {
        logic             grey;        // all channels equal
        logic             black;       // maximum is zero
        logic [PCT_W-1:0] brightness;
    } side_t;

endpackage

`default_nettype wire

FILE: rtl/rgbhsv_front.sv
// Front stages: channel max/min, sector select, divider operands and brightness.
`default_nettype none

module rgbhsv_front import rgbhsv_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  pix_in_t pix,
    output div_in_t hue_div,
    output div_in_t sat_div,
    output side_t   side
);

    localparam int SCL_W = CH_W + PCT_W;   // cmax * 100

    // Stage A: find max, min and the sector
    logic [CH_W-1:0] cmax_a, cmin_a, pos_a, neg_a;
    hue_sect_t       sect_a;

    always_comb begin
        if (pix.red >= pix.green && pix.red >= pix.blue) begin
            sect_a = SECT_RED;
            cmax_a = pix.red;
        end else if (pix.green >= pix.blue) begin
            sect_a = SECT_GREEN;
            cmax_a = pix.green;
        end else begin
            sect_a = SECT_BLUE;
            cmax_a = pix.blue;
        end
        cmin_a = pix.red;
        if (pix.green < cmin_a) begin
            cmin_a = pix.green;
        end
        if (pix.blue < cmin_a) begin
            cmin_a = pix.blue;
        end
        case (sect_a)
            SECT_RED: begin
                pos_a = pix.green;
                neg_a = pix.blue;
            end
            SECT_GREEN: begin
                pos_a = pix.blue;
                neg_a = pix.red;
            end
            default: begin
                pos_a = pix.red;
                neg_a = pix.green;
            end
        endcase
    end

    logic [CH_W-1:0] cmax_reg, diff_reg, pos_reg, neg_reg;
    hue_sect_t       sect_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cmax_reg <= cmax_a;
            diff_reg <= cmax_a - cmin_a;
            pos_reg  <= pos_a;
            neg_reg  <= neg_a;
            sect_reg <= sect_a;
        end
    end

    // Stage B: build numerators and scale brightness
    logic [QUO_W-1:0] ofs_b;
    logic [NUM_W-1:0] up_b, dn_b, base_b;
    logic [SCL_W-1:0] scl_b;
    logic [SCL_W:0]   rnd_b;
    div_in_t          hue_next, sat_next;
    side_t            side_next;

    always_comb begin
        case (sect_reg)
            SECT_RED:   ofs_b = QUO_W'(HUE_RED);
            SECT_GREEN: ofs_b = QUO_W'(HUE_GRN);
            SECT_BLUE:  ofs_b = QUO_W'(HUE_BLU);
            default:    ofs_b = '0;
        endcase
        up_b   = NUM_W'(HUE_STEP * int'(pos_reg));
        dn_b   = NUM_W'(HUE_STEP * int'(neg_reg));
        base_b = NUM_W'(int'(ofs_b) * int'(diff_reg));

        hue_next.num = base_b + up_b - dn_b;
        hue_next.den = diff_reg;
        sat_next.num = NUM_W'(PCT_FULL * int'(diff_reg));
        sat_next.den = cmax_reg;

        // divide by 255: (x + (x >> 8) + 1) >> 8
        scl_b = SCL_W'(PCT_FULL * int'(cmax_reg));
        rnd_b = (SCL_W+1)'(scl_b) + (SCL_W+1)'(scl_b >> CH_W) + (SCL_W+1)'(1);

        side_next.grey       = (diff_reg == '0);
        side_next.black      = (cmax_reg == '0);
        side_next.brightness = PCT_W'(rnd_b >> CH_W);
    end

    div_in_t hue_div_reg, sat_div_reg;
    side_t   side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_div_reg <= hue_next;
            sat_div_reg <= sat_next;
            side_reg    <= side_next;
        end
    end

    assign hue_div = hue_div_reg;
    assign sat_div = sat_div_reg;
    assign side    = side_reg;

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module rgbhsv_div import rgbhsv_pkg::*; #(
    parameter int DEN_W = CH_W,
    parameter int Q_W   = QUO_W
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [DEN_W+Q_W-1:0] num,
    input  logic [DEN_W-1:0]     den,
    output logic [Q_W-1:0]       quo
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : gen_step
        logic [DEN_W-1:0] rem_in, den_in;
        logic [Q_W-1:0]   low_in, quo_in;
        logic [DEN_W:0]   trial, sub;
        logic             ge;

        // Take operands from the port or the previous step
        if (g == 0) begin : gen_first
            assign rem_in = num[DEN_W+Q_W-1:Q_W];
            assign low_in = num[Q_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end else begin : gen_next
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        // Shift in one numerator bit, subtract when it fits
        assign trial = {rem_in, low_in[Q_W-1]};
        assign sub   = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[g] <= low_in << 1;
                den_reg[g] <= den_in;
                quo_reg[g] <= {quo_in[Q_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_back.sv
// Output stage: hue wrap, grey and black cases, output register.
`default_nettype none

module rgbhsv_back import rgbhsv_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  side_t            side,
    input  logic [QUO_W-1:0] hue_quo,
    input  logic [QUO_W-1:0] sat_quo,
    output hsv_out_t         res
);

    hsv_out_t res_next, res_reg;

    // Wrap the red sector into 0..359 and force the degenerate cases
    always_comb begin
        if (side.grey) begin
            res_next.hue = '0;
        end else if (hue_quo >= HUE_WRAP) begin
            res_next.hue = HUE_W'(hue_quo - HUE_WRAP);
        end else begin
            res_next.hue = HUE_W'(hue_quo);
        end
        res_next.saturation = side.black ? '0 : sat_quo[PCT_W-1:0];
        res_next.brightness = side.brightness;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel pipeline.
//
//  Channel  Dir  Handshake           Payload
//  s_       in   s_valid / s_ready   s_data : pix_in_t  (red, green, blue)
//  m_       out  m_valid / m_ready   m_data : hsv_out_t (hue, saturation, brightness)
//
// One pixel per clock while the output is not stalled. Stages: max/min stage, operand stage,
// nine divider steps (one quotient bit each), output register.
// Reset clears only the valid bits; payload registers are not reset.
// When the output holds a beat that is not taken, the whole pipeline freezes
// and s_ready drops in the same cycle.
`default_nettype none

module rgb_to_hsv_pixel import rgbhsv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pix_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hsv_out_t m_data
);

    localparam int NSTG = QUO_W + 3;

    logic            en;
    logic [NSTG-1:0] valid_reg;
    div_in_t         hue_div, sat_div;
    side_t           side_b;
    side_t           side_reg [QUO_W];
    logic [QUO_W-1:0] hue_quo, sat_quo;

    // Advance everything unless the output beat is stuck
    assign en      = !valid_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTG-2:0], s_valid};
        end
    end

    rgbhsv_front u_front (
        .aclk    (aclk),
        .en      (en),
        .pix     (s_data),
        .hue_div (hue_div),
        .sat_div (sat_div),
        .side    (side_b)
    );

    rgbhsv_div #(.DEN_W(CH_W), .Q_W(QUO_W)) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (hue_div.num),
        .den  (hue_div.den),
        .quo  (hue_quo)
    );

    rgbhsv_div #(.DEN_W(CH_W), .Q_W(QUO_W)) u_sat_div (
        .aclk (aclk),
        .en   (en),
        .num  (sat_div.num),
        .den  (sat_div.den),
        .quo  (sat_quo)
    );

    // Carry the sideband alongside the divider steps
    for (genvar g = 0; g < QUO_W; g++) begin : gen_side
        always_ff @(posedge aclk) begin
            if (en) begin
                if (g == 0) begin
                    side_reg[g] <= side_b;
                end else begin
                    side_reg[g] <= side_reg[(g > 0) ? g-1 : 0];
                end
            end
        end
    end

    rgbhsv_back u_back (
        .aclk    (aclk),
        .en      (en),
        .side    (side_reg[QUO_W-1]),
        .hue_quo (hue_quo),
        .sat_quo (sat_quo),
        .res     (m_data)
    );

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_checker.sv
// Port checker for the RGB to HSV pipeline, bound to the top level.
`default_nettype none

module rgbhsv_checker import rgbhsv_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input pix_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input hsv_out_t m_data
);

    // Output beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    // Results stay in range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hue < HUE_W'(360) && m_data.saturation <= PCT_W'(100)
                    && m_data.brightness <= PCT_W'(100))
        else $error("result field out of range");

    // Input is held off only by a stuck output beat
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the RGB to HSV pixel pipeline.
`timescale 1ns / 1ps

module tb;
    import rgbhsv_pkg::*;

    // Cycles with no beat on either channel before the run is given up
    localparam int QUIET_LIMIT = 4000;
    // Cycles to watch for stray beats after the last expected one
    localparam int DRAIN_CYCLES = 24;
    localparam int DIR_N = 23;
    localparam int RAND_PER_PHASE = 195;

    typedef enum logic [1:0] {
        PH_FLOW,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    typedef struct {
        pix_in_t     pix;
        bit          typed;
        hsv_out_t    want;
        idle_phase_t phase;
    } pixel_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pix_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hsv_out_t m_data;

    // Directed pixels: red, green, blue, typed flag, hue, saturation, brightness
    int unsigned dir_tab [DIR_N][7] = '{
        '{  0,   0,   0, 1,   0,   0,   0},   // black
        '{255, 255, 255, 1,   0,   0, 100},   // white
        '{255,   0,   0, 1,   0, 100, 100},
        '{  0, 255,   0, 1, 120, 100, 100},
        '{  0,   0, 255, 1, 240, 100, 100},
        '{255, 255,   0, 1,  60, 100, 100},   // red and green tied
        '{  0, 255, 255, 1, 180, 100, 100},   // green and blue tied
        '{255,   0, 255, 1, 300, 100, 100},   // red and blue tied
        '{128, 128, 128, 1,   0,   0,  50},   // mid grey
        '{  1,   1,   1, 1,   0,   0,   0},
        '{  1,   0,   0, 1,   0, 100,   0},
        '{255,   0,   1, 0,   0,   0,   0},   // hue just below the wrap
        '{255,   1,   0, 0,   0,   0,   0},
        '{  1,   0, 255, 0,   0,   0,   0},
        '{  0,   1, 255, 0,   0,   0,   0},
        '{255, 254, 253, 0,   0,   0,   0},
        '{  1,   2,   3, 0,   0,   0,   0},
        '{200, 200,  10, 0,   0,   0,   0},
        '{ 10, 200, 200, 0,   0,   0,   0},
        '{200,  10, 200, 0,   0,   0,   0},
        '{170,  85, 255, 0,   0,   0,   0},
        '{ 85, 170,  15, 0,   0,   0,   0},
        '{254, 127,   1, 0,   0,   0,   0}
    };

    pixel_row_t  pixel_plan [$];
    hsv_out_t    hsv_due [$];
    int          send_idx = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    bit          plan_done = 1'b0;
    idle_phase_t cur_phase = PH_FLOW;

    rgb_to_hsv_pixel uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Expected hue, saturation and value of one pixel
    function automatic hsv_out_t predict_hsv(pix_in_t p);
        int unsigned r, g, b, top, bot, span, hue;
        hsv_out_t    res;
        r = 32'(p.red);
        g = 32'(p.green);
        b = 32'(p.blue);
        top = r;
        bot = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bot) bot = g;
        if (b < bot) bot = b;
        span = top - bot;
        if (span == 0)
            hue = 0;
        else if (top == r)
            hue = ((HUE_STEP * g + HUE_RED * span - HUE_STEP * b) / span) % HUE_RED;
        else if (top == g)
            hue = (HUE_STEP * b + HUE_GRN * span - HUE_STEP * r) / span;
        else
            hue = (HUE_STEP * r + HUE_BLU * span - HUE_STEP * g) / span;
        res.hue        = HUE_W'(hue);
        res.saturation = (top == 0) ? '0 : PCT_W'((span * PCT_FULL) / top);
        res.brightness = PCT_W'((top * PCT_FULL) / 255);
        return res;
    endfunction

    // Percent of cycles one side idles in a given phase
    function automatic int unsigned gap_pct(idle_phase_t ph, bit sender);
        case (ph)
            PH_SRC_IDLE:  return sender ? 58 : 0;
            PH_SNK_STALL: return sender ? 0 : 58;
            PH_BOTH_IDLE: return 21;
            default:      return 0;
        endcase
    endfunction

    task automatic check_field(input string label, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want) begin
            $display("%0t tb: %s expected %0d got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Build the pixel plan, then release reset and wait for the drain
    initial begin
        pixel_row_t  row;
        logic [7:0]  r, g, b;
        int unsigned pick;
        for (int i = 0; i < DIR_N; i++) begin
            row.pix   = '{red: CH_W'(dir_tab[i][0]), green: CH_W'(dir_tab[i][1]),
                          blue: CH_W'(dir_tab[i][2])};
            row.typed = dir_tab[i][3] != 0;
            row.want  = '{hue: HUE_W'(dir_tab[i][4]), saturation: PCT_W'(dir_tab[i][5]),
                          brightness: PCT_W'(dir_tab[i][6])};
            row.phase = PH_FLOW;
            pixel_plan.push_back(row);
        end
        for (int i = 0; i < 4 * RAND_PER_PHASE; i++) begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            pick = $urandom_range(9);
            // bias toward grey, ties and the ends of the range
            case (pick)
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    g = r;
                    b = 8'($urandom_range(r));
                end
                2: begin
                    b = g;
                    r = 8'($urandom_range(g));
                end
                3: begin
                    r = 8'($urandom_range(3));
                    g = 8'($urandom_range(3));
                    b = 8'($urandom_range(3));
                end
                4: begin
                    r = 8'(252 + $urandom_range(3));
                    g = 8'(252 + $urandom_range(3));
                    b = 8'(252 + $urandom_range(3));
                end
                default: ;
            endcase
            row.pix   = '{red: r, green: g, blue: b};
            row.typed = 1'b0;
            row.want  = '0;
            row.phase = idle_phase_t'(i / RAND_PER_PHASE);
            pixel_plan.push_back(row);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(plan_done && hsv_due.size() == 0)) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && hsv_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Drive pixels, score results and watch for a hang
    always @(posedge aclk) begin
        bit       took_in;
        bit       took_out;
        hsv_out_t due;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            took_in  = s_valid && s_ready;
            took_out = m_valid && m_ready;

            // record the expectation of the accepted pixel
            if (took_in) begin
                hsv_due.push_back(pixel_plan[send_idx].typed ? pixel_plan[send_idx].want
                                  : predict_hsv(pixel_plan[send_idx].pix));
                send_idx++;
                if (send_idx == pixel_plan.size()) plan_done = 1'b1;
            end

            // compare the result beat with the oldest expectation
            if (took_out) begin
                if (hsv_due.size() == 0) begin
                    $display("%0t tb: result beat with none expected, got %0d/%0d/%0d",
                             $time, m_data.hue, m_data.saturation, m_data.brightness);
                    mismatches++;
                end else begin
                    due = hsv_due.pop_front();
                    check_field("hue", due.hue, m_data.hue);
                    check_field("saturation", 9'(due.saturation), 9'(m_data.saturation));
                    check_field("brightness", 9'(due.brightness), 9'(m_data.brightness));
                end
            end

            // present the next pixel unless the sender idles this cycle
            if (!s_valid || took_in) begin
                if (send_idx < pixel_plan.size()) begin
                    cur_phase = pixel_plan[send_idx].phase;
                    if ($urandom_range(99) < gap_pct(cur_phase, 1'b1)) begin
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_data  <= pixel_plan[send_idx].pix;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end

            m_ready <= ($urandom_range(99) >= gap_pct(cur_phase, 1'b0));

            // give up when no beat moves for too long
            if (took_in || took_out)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t tb: no beat for %0d cycles", $time, quiet_cycles);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

endmodule
